// ===== hdl/sync_word_length_deframer_assert.svh =====
// Assertion macros used by the deframer's top level module.
`ifndef SYNC_WORD_LENGTH_DEFRAMER_ASSERT_SVH
`define SYNC_WORD_LENGTH_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWLD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/swld_pkg.sv =====
// Types and constants shared by the sync word deframer modules.
package swld_pkg;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	localparam logic [23:0] SYNC_HEAD = 24'hAABBCC;
	localparam logic [7:0]  SYNC_LAST = 8'hDD;
	localparam logic [3:0]  HDR_LAST_IDX = 4'd11;
	localparam logic [32:0] FRAME_OVERHEAD = 33'd16;

	localparam int unsigned LIMIT_W = 21;
	localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 21'd4096;

	localparam logic [1:0] REG_FRAME_LIMIT = 2'd0;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef struct packed {
		logic        valid;
		logic [7:0]  data;
	} beat_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] hdr_lo;
		logic [31:0] hdr_hi;
		logic [31:0] length;
		logic [7:0]  data;
		logic        last;
	} result_t;

endpackage

// ===== hdl/swld_apb_regs.sv =====
// APB configuration register holding the frame limit.
module swld_apb_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [1:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output logic [swld_pkg::LIMIT_W-1:0]    frame_limit
);

	logic [swld_pkg::LIMIT_W-1:0] limit_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == swld_pkg::REG_FRAME_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= swld_pkg::FRAME_LIMIT_RESET;
		end else if (wr_en) begin
			limit_q <= pwdata[swld_pkg::LIMIT_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr)
			swld_pkg::REG_FRAME_LIMIT: prdata = {{(32-swld_pkg::LIMIT_W){1'b0}}, limit_q};
			default:                   prdata = 32'd0;
		endcase
	end

	assign frame_limit = limit_q;

endmodule

// ===== hdl/swld_in_stage.sv =====
// Input register stage that holds one received byte beat.
module swld_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	output logic            in_stall,
	input  logic            advance,
	output swld_pkg::beat_t beat_s1
);

	logic       valid_s1;
	logic [7:0] data_s1;

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_byte;
		end
	end

	assign beat_s1.valid = valid_s1;
	assign beat_s1.data  = data_s1;

endmodule

// ===== hdl/swld_frame_ctl.sv =====
// Frame state machine, header assembly and result register.
module swld_frame_ctl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  swld_pkg::beat_t              beat_s1,
	input  logic [swld_pkg::LIMIT_W-1:0] frame_limit,
	input  logic                         out_stall,
	output logic                         advance,
	output logic                         out_valid,
	output swld_pkg::result_t            result_s2
);

	swld_pkg::phase_t  phase_q, phase_d;
	logic [23:0]       window_q, window_d;
	logic [3:0]        count_q, count_d;
	logic [63:0]       hdr_q, hdr_d;
	logic [31:0]       len_q, len_d;
	logic [31:0]       rem_q, rem_d;
	logic [31:0]       rem_dec;
	logic              sync_hit;
	logic              hdr_done;
	logic              oversize;
	logic              res_valid;
	swld_pkg::result_t res;
	logic              out_valid_q;
	logic [7:0]        b;

	assign b = beat_s1.data;
	// The byte in the input stage moves on only when the result slot is empty or its beat is taken.
	assign advance = beat_s1.valid && (!out_valid_q || !out_stall);

	assign sync_hit = (window_q == swld_pkg::SYNC_HEAD) && (b == swld_pkg::SYNC_LAST);
	assign hdr_done = (count_q == swld_pkg::HDR_LAST_IDX);
	assign rem_dec  = rem_q - 32'd1;
	assign oversize = ({1'b0, len_d} + swld_pkg::FRAME_OVERHEAD)
		>= {{(33-swld_pkg::LIMIT_W){1'b0}}, frame_limit};

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			swld_pkg::PH_HEADER: begin
				if (hdr_done) begin
					if (oversize || (len_d == 32'd0)) begin
						phase_d = swld_pkg::PH_HUNT;
					end else begin
						phase_d = swld_pkg::PH_PAYLOAD;
					end
				end
			end
			swld_pkg::PH_PAYLOAD: begin
				if (rem_dec == 32'd0) begin
					phase_d = swld_pkg::PH_HUNT;
				end
			end
			default: begin
				phase_d = sync_hit ? swld_pkg::PH_HEADER : swld_pkg::PH_HUNT;
			end
		endcase
	end

	// Datapath and result for the byte in the input stage.
	always_comb begin
		window_d  = window_q;
		count_d   = count_q;
		hdr_d     = hdr_q;
		len_d     = len_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			swld_pkg::PH_HEADER: begin
				if (count_q[3]) begin
					len_d[{count_q[1:0], 3'b000} +: 8] = b;
				end else begin
					hdr_d[{count_q[2:0], 3'b000} +: 8] = b;
				end
				count_d = count_q + 4'd1;
				if (hdr_done) begin
					count_d  = 4'd0;
					window_d = 24'd0;
					if (!oversize) begin
						res_valid  = 1'b1;
						res.kind   = swld_pkg::KIND_HEADER;
						res.hdr_lo = hdr_d[31:0];
						res.hdr_hi = hdr_d[63:32];
						res.length = len_d;
						res.last   = (len_d == 32'd0);
						rem_d      = len_d;
					end
				end
			end
			swld_pkg::PH_PAYLOAD: begin
				rem_d      = rem_dec;
				res_valid  = 1'b1;
				res.kind   = swld_pkg::KIND_PAYLOAD;
				res.length = len_q;
				res.data   = b;
				res.last   = (rem_dec == 32'd0);
				if (rem_dec == 32'd0) begin
					window_d = 24'd0;
				end
			end
			default: begin
				if (sync_hit) begin
					count_d  = 4'd0;
					hdr_d    = 64'd0;
					len_d    = 32'd0;
					window_d = 24'd0;
				end else begin
					window_d = {window_q[15:0], b};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= swld_pkg::PH_HUNT;
			window_q <= 24'd0;
			count_q  <= 4'd0;
			hdr_q    <= 64'd0;
			len_q    <= 32'd0;
			rem_q    <= 32'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			count_q  <= count_d;
			hdr_q    <= hdr_d;
			len_q    <= len_d;
			rem_q    <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			result_s2 <= res;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/sync_word_length_deframer.sv =====
// Top level of the sync word, length prefixed byte stream deframer.
// A byte beat passes through the input register and then the result register before its result beat is presented.
// Throughput: one byte beat per cycle while the output is not stalled; the input
// register and the result register are the only stages.
// Reset: asynchronous, clears phase, sync window and both valid flags; frame_limit is 4096.
`include "sync_word_length_deframer_assert.svh"

module sync_word_length_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        item_kind,
	output logic [31:0] header_word_low,
	output logic [31:0] header_word_high,
	output logic [31:0] payload_length,
	output logic [7:0]  data_byte,
	output logic        last_of_frame
);

	logic [swld_pkg::LIMIT_W-1:0] frame_limit;
	logic                         advance;
	swld_pkg::beat_t              beat_s1;
	swld_pkg::result_t            result_s2;

	swld_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.frame_limit (frame_limit)
	);

	swld_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.in_stall (in_stall),
		.advance  (advance),
		.beat_s1  (beat_s1)
	);

	swld_frame_ctl u_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat_s1     (beat_s1),
		.frame_limit (frame_limit),
		.out_stall   (out_stall),
		.advance     (advance),
		.out_valid   (out_valid),
		.result_s2   (result_s2)
	);

	assign item_kind        = result_s2.kind;
	assign header_word_low  = result_s2.hdr_lo;
	assign header_word_high = result_s2.hdr_hi;
	assign payload_length   = result_s2.length;
	assign data_byte        = result_s2.data;
	assign last_of_frame    = result_s2.last;

	`SWLD_ASSERT_SAME(a_empty_frame_last,
		out_valid && (item_kind == swld_pkg::KIND_HEADER) && (payload_length == 32'd0),
		last_of_frame, "header beat of an empty frame is not marked last")
	`SWLD_ASSERT_SAME(a_payload_no_header,
		out_valid && (item_kind == swld_pkg::KIND_PAYLOAD),
		(header_word_low == 32'd0) && (header_word_high == 32'd0),
		"payload beat carries header words")
	`SWLD_ASSERT_SAME(a_stall_needs_full_stage, in_stall,
		beat_s1.valid && out_valid && out_stall,
		"input stalled while the pipeline can move")
	`SWLD_ASSERT_NEXT(a_limit_written,
		psel && penable && pwrite && (paddr == swld_pkg::REG_FRAME_LIMIT),
		frame_limit == $past(pwdata[swld_pkg::LIMIT_W-1:0]),
		"frame limit write not taken")

endmodule

// ===== sim/sync_word_length_deframer_checker.sv =====
// Checker for the deframer: predicts the result beats from the accepted byte beats and compares.
module sync_word_length_deframer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        item_kind,
	input  logic [31:0] header_word_low,
	input  logic [31:0] header_word_high,
	input  logic [31:0] payload_length,
	input  logic [7:0]  data_byte,
	input  logic        last_of_frame,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [swld_pkg::LIMIT_W-1:0] limit_q;
	logic [23:0]                  window_q;
	swld_pkg::phase_t             phase_q;
	logic [3:0]                   hdr_idx;
	logic [63:0]                  hdr_bytes;
	logic [31:0]                  frame_len;
	logic [31:0]                  bytes_left;
	swld_pkg::result_t            results_due[$];
	swld_pkg::result_t            want;

	function automatic void advance_deframer(input logic [7:0] b);
		swld_pkg::result_t r;
		r = '0;
		case (phase_q)
			swld_pkg::PH_HEADER: begin
				if (hdr_idx < 4'd8)
					hdr_bytes[8*hdr_idx +: 8] = b;
				else
					frame_len[8*(hdr_idx - 4'd8) +: 8] = b;
				if (hdr_idx != swld_pkg::HDR_LAST_IDX) begin
					hdr_idx++;
					return;
				end
				hdr_idx  = '0;
				window_q = '0;
				// The total frame size is compared in 33 bits so a huge length cannot wrap.
				if ({1'b0, frame_len} + swld_pkg::FRAME_OVERHEAD >= 33'(limit_q)) begin
					phase_q = swld_pkg::PH_HUNT;
					return;
				end
				r.kind   = swld_pkg::KIND_HEADER;
				r.hdr_lo = hdr_bytes[31:0];
				r.hdr_hi = hdr_bytes[63:32];
				r.length = frame_len;
				r.last   = (frame_len == 32'd0);
				results_due.push_back(r);
				bytes_left = frame_len;
				phase_q = (frame_len == 32'd0) ? swld_pkg::PH_HUNT : swld_pkg::PH_PAYLOAD;
			end
			swld_pkg::PH_PAYLOAD: begin
				bytes_left--;
				r.kind   = swld_pkg::KIND_PAYLOAD;
				r.length = frame_len;
				r.data   = b;
				r.last   = (bytes_left == 32'd0);
				results_due.push_back(r);
				if (bytes_left == 32'd0) begin
					phase_q  = swld_pkg::PH_HUNT;
					window_q = '0;
				end
			end
			default: begin
				phase_q = swld_pkg::PH_HUNT;
				if (window_q == swld_pkg::SYNC_HEAD && b == swld_pkg::SYNC_LAST) begin
					phase_q   = swld_pkg::PH_HEADER;
					hdr_idx   = '0;
					hdr_bytes = '0;
					frame_len = '0;
					window_q  = '0;
				end else begin
					window_q = {window_q[15:0], b};
				end
			end
		endcase
	endfunction

	task automatic compare_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    = swld_pkg::FRAME_LIMIT_RESET;
			window_q   = '0;
			phase_q    = swld_pkg::PH_HUNT;
			hdr_idx    = '0;
			hdr_bytes  = '0;
			frame_len  = '0;
			bytes_left = '0;
			fail_count = 0;
			results_due.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == swld_pkg::REG_FRAME_LIMIT)
				limit_q = pwdata[swld_pkg::LIMIT_W-1:0];
			// The result beat is checked before this edge's byte beat is predicted, so a
			// spurious result can never be matched against an expectation made at the same edge.
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result beat arrived with no expected result");
					fail_count++;
				end else begin
					want = results_due.pop_front();
					compare_field("item_kind", want.kind, item_kind);
					compare_field("header_word_low", want.hdr_lo, header_word_low);
					compare_field("header_word_high", want.hdr_hi, header_word_high);
					compare_field("payload_length", want.length, payload_length);
					compare_field("data_byte", want.data, data_byte);
					compare_field("last_of_frame", want.last, last_of_frame);
				end
			end
			if (in_valid && !in_stall)
				advance_deframer(in_byte);
		end
		pending = results_due.size();
	end

endmodule

// ===== sim/sync_word_length_deframer_tb.sv =====
// Testbench top: drives byte beats and frame limit writes into the deframer and gives the verdict.
module sync_word_length_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = swld_pkg::REG_FRAME_LIMIT;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        item_kind;
	logic [31:0] header_word_low;
	logic [31:0] header_word_high;
	logic [31:0] payload_length;
	logic [7:0]  data_byte;
	logic        last_of_frame;
	int          fail_count;
	int          pending;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	logic        hold_go = 1'b0;
	logic        hold_done = 1'b0;
	int unsigned hold_left = 0;
	int unsigned cur_limit = swld_pkg::FRAME_LIMIT_RESET;
	logic [7:0]  stream[$];

	sync_word_length_deframer u_top (.*);

	sync_word_length_deframer_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off that lets the block fill up.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	task automatic push_sync_prefix(input int n);
		for (int i = 0; i < n; i++)
			stream.push_back(swld_pkg::SYNC_HEAD[23-8*i -: 8]);
	endtask

	// Sync word, both header words and the length, little endian; the payload only when
	// the frame fits under the current limit, since a dropped frame sends the block back to hunting.
	task automatic push_frame(input logic [63:0] words, input logic [31:0] len);
		push_sync_prefix(3);
		stream.push_back(swld_pkg::SYNC_LAST);
		for (int i = 0; i < 8; i++)
			stream.push_back(words[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			stream.push_back(len[8*i +: 8]);
		if ({32'd0, len} + 64'd16 < 64'(cur_limit)) begin
			for (int i = 0; i < len; i++)
				stream.push_back(8'($urandom));
		end
	endtask

	task automatic add_traffic(input int unsigned budget);
		int unsigned pick;
		logic [31:0] len;
		logic [63:0] words;
		while (stream.size() < budget) begin
			pick = $urandom_range(0, 99);
			words = {$urandom, $urandom};
			if (pick < 55) begin
				// A partial sync word in front makes the window slide onto the real one.
				if ($urandom_range(0, 3) == 0)
					push_sync_prefix($urandom_range(1, 3));
				push_frame(words, $urandom_range(0, 12));
			end else if (pick < 70) begin
				len = $urandom | 32'h0020_0000;
				if ($urandom_range(0, 1)) begin
					// The length ends in the first three sync bytes; after the drop the
					// following DD must not complete a match.
					len = {swld_pkg::SYNC_HEAD[7:0], swld_pkg::SYNC_HEAD[15:8],
						swld_pkg::SYNC_HEAD[23:16], len[7:0]};
					push_frame(words, len);
					stream.push_back(swld_pkg::SYNC_LAST);
				end else begin
					// A sync word hidden in the dropped header must not be found again.
					words[31:0] = {swld_pkg::SYNC_LAST, swld_pkg::SYNC_HEAD[7:0],
						swld_pkg::SYNC_HEAD[15:8], swld_pkg::SYNC_HEAD[23:16]};
					push_frame(words, len);
				end
			end else if (pick < 85) begin
				// Payload ends in the first three sync bytes, then DD: the window was cleared.
				len = $urandom_range(3, 12);
				push_frame(words, len);
				if ({32'd0, len} + 64'd16 < 64'(cur_limit)) begin
					stream[stream.size()-3] = swld_pkg::SYNC_HEAD[23:16];
					stream[stream.size()-2] = swld_pkg::SYNC_HEAD[15:8];
					stream[stream.size()-1] = swld_pkg::SYNC_HEAD[7:0];
				end
				stream.push_back(swld_pkg::SYNC_LAST);
			end else begin
				repeat ($urandom_range(1, 6))
					stream.push_back(8'($urandom));
				if ($urandom_range(0, 1)) begin
					push_sync_prefix($urandom_range(1, 3));
					stream.push_back(8'($urandom));
				end
			end
		end
	endtask

	// The last beat is left on the bus; wait_idle drops valid once the sender is done.
	task automatic send_stream();
		logic [7:0] b;
		while (stream.size() != 0) begin
			b = stream.pop_front();
			while ($urandom_range(0, 99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte  <= b;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
		end
	endtask

	task automatic write_limit(input logic [swld_pkg::LIMIT_W-1:0] value);
		logic [31:0] word;
		word = $urandom;
		word[swld_pkg::LIMIT_W-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= swld_pkg::REG_FRAME_LIMIT;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid and drain every expected result, then give time to clear
	// the two register stages.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned plan [6];
		plan = '{swld_pkg::FRAME_LIMIT_RESET, 17, 16, 0, 1048576, 2097151};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme bytes while hunting, an empty payload frame, then a near miss on the sync word.
		stream.push_back(8'h00);
		stream.push_back(8'hFF);
		push_frame(64'h7FFE_8001_AA55_00FF, 32'd0);
		push_sync_prefix(3);
		stream.push_back(8'h11);
		send_stream();

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			if (p != 0) begin
				cur_limit = (plan[p] == 0) ? $urandom_range(17, 300) : plan[p];
				write_limit(cur_limit[swld_pkg::LIMIT_W-1:0]);
			end
			for (int m = 0; m < 4; m++) begin
				send_idle_pct = (m == 1) ? 48 : (m == 3) ? 24 : 0;
				stall_pct     = (m == 2) ? 48 : (m == 3) ? 24 : 0;
				if (p == 0 && m == 0) begin
					// A frame that fits puts a result in the way of the long hold-off.
					hold_go <= 1'b1;
					push_frame({$urandom, $urandom}, 32'd8);
				end
				if (m == 0 && cur_limit >= 17 && cur_limit <= 300) begin
					// The largest frame that fits, then the smallest one that is dropped.
					push_frame({$urandom, $urandom}, cur_limit - 17);
					push_frame({$urandom, $urandom}, cur_limit - 16);
					send_stream();
				end
				add_traffic(60);
				send_stream();
			end
		end

		wait_idle();
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sync_word_length_deframer.f =====
+incdir+hdl
hdl/swld_pkg.sv
hdl/swld_apb_regs.sv
hdl/swld_in_stage.sv
hdl/swld_frame_ctl.sv
hdl/sync_word_length_deframer.sv
sim/sync_word_length_deframer_checker.sv
sim/sync_word_length_deframer_tb.sv
